/* design/ubs_pkg.sv */
// ----------------------------------------------------------------------------
// ubs_pkg
// Shared widths, protocol bytes, function codes and phase encoding for the
// boot image sender.
// ----------------------------------------------------------------------------
package ubs_pkg;

    localparam int RX_BYTES           = 4;
    localparam int RX_LANES_DEFAULT   = 4;

    localparam int FUNC_W     = 3;
    localparam int COUNT_W    = 3;
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int LEN_W      = 16;
    localparam int PHASE_W    = 3;
    localparam int LIMIT_W    = 20;
    localparam int TIMER_W    = LIMIT_W + 1;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 20;

    localparam logic [BYTE_W-1:0] BYTE_SOH = 8'h01;
    localparam logic [BYTE_W-1:0] BYTE_STX = 8'h02;
    localparam logic [BYTE_W-1:0] BYTE_ACK = 8'h06;

    localparam logic [LIMIT_W-1:0] LIMIT_AT_RESET = 20'd1000000;

    localparam logic [LEN_W-1:0] LEN_HEADER = 16'd3;
    localparam logic [LEN_W-1:0] LEN_ACK    = 16'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_LENGTH  = 1'b0,
        REG_TIMEOUT_LIMIT = 1'b1
    } reg_index_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_POLL       = 3'd0,
        FUNC_RESTART    = 3'd1,
        FUNC_RESET_IDLE = 3'd2,
        FUNC_FORCE_DONE = 3'd3,
        FUNC_IMAGE_BYTE = 3'd4
    } func_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE  = 2'd0,
        KIND_SHORT = 2'd1,
        KIND_IMAGE = 2'd2
    } kind_t;

    typedef enum logic [6:0] {
        PH_IDLE      = 7'b0000001,
        PH_SEEN_STX  = 7'b0000010,
        PH_SENT_SOH  = 7'b0000100,
        PH_SEEN_ACK  = 7'b0001000,
        PH_SENT_IMG  = 7'b0010000,
        PH_SEND_ACK  = 7'b0100000,
        PH_DONE      = 7'b1000000
    } phase_t;

    localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_SEEN_STX = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_SENT_SOH = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_CODE_SEEN_ACK = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_CODE_SENT_IMG = 3'd4;
    localparam logic [PHASE_W-1:0] PHASE_CODE_SEND_ACK = 3'd5;
    localparam logic [PHASE_W-1:0] PHASE_CODE_DONE     = 3'd6;

    typedef struct packed {
        logic [LEN_W-1:0]   image_length;
        logic [LIMIT_W-1:0] timeout_limit;
    } cfg_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        unique case (ph)
            PH_IDLE:     code = PHASE_CODE_IDLE;
            PH_SEEN_STX: code = PHASE_CODE_SEEN_STX;
            PH_SENT_SOH: code = PHASE_CODE_SENT_SOH;
            PH_SEEN_ACK: code = PHASE_CODE_SEEN_ACK;
            PH_SENT_IMG: code = PHASE_CODE_SENT_IMG;
            PH_SEND_ACK: code = PHASE_CODE_SEND_ACK;
            default:     code = PHASE_CODE_DONE;
        endcase
        return code;
    endfunction

endpackage

/* design/ubs_if.sv */
// ----------------------------------------------------------------------------
// ubs_if
// Valid/ready channel interfaces for poll items and transmit results.
// ----------------------------------------------------------------------------
interface ubs_in_if;
    import ubs_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [COUNT_W-1:0] rx_count;
    logic [BYTE_W-1:0]  rx_byte0;
    logic [BYTE_W-1:0]  rx_byte1;
    logic [BYTE_W-1:0]  rx_byte2;
    logic [BYTE_W-1:0]  rx_byte3;

    modport source (
        output valid, func, rx_count, rx_byte0, rx_byte1, rx_byte2, rx_byte3,
        input  ready
    );
    modport sink (
        input  valid, func, rx_count, rx_byte0, rx_byte1, rx_byte2, rx_byte3,
        output ready
    );
endinterface

interface ubs_out_if;
    import ubs_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  tx_kind;
    logic [LEN_W-1:0]   tx_len;
    logic [BYTE_W-1:0]  tx_byte0;
    logic [BYTE_W-1:0]  tx_byte1;
    logic [BYTE_W-1:0]  tx_byte2;
    logic [PHASE_W-1:0] phase;
    logic               timed_out;
    logic               finished;

    modport source (
        output valid, tx_kind, tx_len, tx_byte0, tx_byte1, tx_byte2, phase,
               timed_out, finished,
        input  ready
    );
    modport sink (
        input  valid, tx_kind, tx_len, tx_byte0, tx_byte1, tx_byte2, phase,
               timed_out, finished,
        output ready
    );
endinterface

/* design/ubs_lane.sv */
// ----------------------------------------------------------------------------
// ubs_lane
// One receive lane: flags an STX byte when the lane holds a received byte.
// ----------------------------------------------------------------------------
module ubs_lane (
    input  logic [ubs_pkg::BYTE_W-1:0] rx_byte,
    input  logic                       lane_en,
    output logic                       stx_hit
);
    import ubs_pkg::*;

    assign stx_hit = lane_en && (rx_byte == BYTE_STX);

endmodule

/* design/ubs_stx_detect.sv */
// ----------------------------------------------------------------------------
// ubs_stx_detect
// Receive lanes side by side, merged into one "STX seen in this poll" flag.
// ----------------------------------------------------------------------------
module ubs_stx_detect #(
    parameter int NUM_LANES = ubs_pkg::RX_BYTES
) (
    input  logic [ubs_pkg::RX_BYTES-1:0][ubs_pkg::BYTE_W-1:0] rx_bytes,
    input  logic [ubs_pkg::COUNT_W-1:0]                       rx_count,
    output logic                                              stx_seen
);
    import ubs_pkg::*;

    logic [NUM_LANES-1:0] lane_hit;

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        ubs_lane u_lane (
            .rx_byte (rx_bytes[i]),
            .lane_en (COUNT_W'(i) < rx_count),
            .stx_hit (lane_hit[i])
        );
    end

    // merge stage
    assign stx_seen = |lane_hit;

endmodule

/* design/ubs_core.sv */
// ----------------------------------------------------------------------------
// ubs_core
// Handshake phase machine, timeout counter, checksum and result register.
// ----------------------------------------------------------------------------
module ubs_core #(
    parameter int NUM_LANES = ubs_pkg::RX_BYTES
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ubs_pkg::cfg_t cfg,
    ubs_in_if.sink        in_ch,
    ubs_out_if.source     out_ch
);
    import ubs_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [TIMER_W-1:0]  timeout_reg, timeout_next;
    logic [BYTE_W-1:0]   checksum_reg, checksum_next;

    logic                out_valid_reg;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [BYTE_W-1:0]   b0_reg, b0_next;
    logic [BYTE_W-1:0]   b1_reg, b1_next;
    logic [BYTE_W-1:0]   b2_reg, b2_next;
    logic [PHASE_W-1:0]  phase_out_reg;
    logic                timed_out_reg;
    logic                finished_reg;

    logic [COUNT_W-1:0]  cnt;
    logic                stx_seen;
    logic                in_xfer;
    logic [TIMER_W-1:0]  timer_reload;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_xfer     = in_ch.valid && in_ch.ready;

    assign cnt = (in_ch.rx_count > COUNT_W'(NUM_LANES)) ? COUNT_W'(NUM_LANES)
                                                         : in_ch.rx_count;
    assign timer_reload = {1'b0, cfg.timeout_limit};

    ubs_stx_detect #(.NUM_LANES(NUM_LANES)) u_stx (
        .rx_bytes ({in_ch.rx_byte3, in_ch.rx_byte2, in_ch.rx_byte1, in_ch.rx_byte0}),
        .rx_count (cnt),
        .stx_seen (stx_seen)
    );

    always_comb
    begin
        phase_next    = phase_reg;
        timeout_next  = timeout_reg;
        checksum_next = checksum_reg;
        kind_next     = KIND_NONE;
        len_next      = '0;
        b0_next       = '0;
        b1_next       = '0;
        b2_next       = '0;
        unique case (func_t'(in_ch.func))
            FUNC_POLL:
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (stx_seen)
                            phase_next = PH_SEEN_STX;
                        // counter floors at -1
                        if (!timeout_reg[TIMER_W-1])
                            timeout_next = timeout_reg - TIMER_W'(1);
                    end
                    PH_SEEN_STX:
                    begin
                        kind_next  = KIND_SHORT;
                        len_next   = LEN_HEADER;
                        b0_next    = BYTE_SOH;
                        b1_next    = cfg.image_length[7:0];
                        b2_next    = cfg.image_length[15:8];
                        phase_next = PH_SENT_SOH;
                    end
                    PH_SENT_SOH:
                    begin
                        if (cnt == COUNT_W'(1))
                            phase_next = (in_ch.rx_byte0 == BYTE_ACK) ? PH_SEEN_ACK
                                                                      : PH_IDLE;
                    end
                    PH_SEEN_ACK:
                    begin
                        kind_next  = KIND_IMAGE;
                        len_next   = cfg.image_length;
                        phase_next = PH_SENT_IMG;
                    end
                    PH_SENT_IMG:
                    begin
                        if (cnt == COUNT_W'(1))
                            phase_next = (in_ch.rx_byte0 == checksum_reg) ? PH_SEND_ACK
                                                                          : PH_IDLE;
                    end
                    PH_SEND_ACK:
                    begin
                        kind_next  = KIND_SHORT;
                        len_next   = LEN_ACK;
                        b0_next    = BYTE_ACK;
                        phase_next = PH_DONE;
                    end
                    default: ;
                endcase
            end
            FUNC_RESTART:
            begin
                phase_next    = PH_IDLE;
                checksum_next = '0;
                timeout_next  = timer_reload;
            end
            FUNC_RESET_IDLE:
            begin
                phase_next   = PH_IDLE;
                timeout_next = timer_reload;
            end
            FUNC_FORCE_DONE: phase_next = PH_DONE;
            FUNC_IMAGE_BYTE: checksum_next = checksum_reg ^ in_ch.rx_byte0;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timeout_reg   <= {1'b0, LIMIT_AT_RESET};
            checksum_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                phase_reg    <= phase_next;
                timeout_reg  <= timeout_next;
                checksum_reg <= checksum_next;
            end
            if (in_xfer)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_reg      <= kind_next;
            len_reg       <= len_next;
            b0_reg        <= b0_next;
            b1_reg        <= b1_next;
            b2_reg        <= b2_next;
            phase_out_reg <= phase_code(phase_next);
            timed_out_reg <= (phase_next == PH_IDLE) && timeout_next[TIMER_W-1];
            finished_reg  <= (phase_next == PH_DONE);
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.tx_kind   = kind_reg;
    assign out_ch.tx_len    = len_reg;
    assign out_ch.tx_byte0  = b0_reg;
    assign out_ch.tx_byte1  = b1_reg;
    assign out_ch.tx_byte2  = b2_reg;
    assign out_ch.phase     = phase_out_reg;
    assign out_ch.timed_out = timed_out_reg;
    assign out_ch.finished  = finished_reg;

    a_xfer_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> out_valid_reg)
        else $error("accepted poll produced no result");

    a_done_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (finished_reg == (phase_out_reg == PHASE_CODE_DONE)))
        else $error("finished flag disagrees with phase");

    a_timeout_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && timed_out_reg) |-> (phase_out_reg == PHASE_CODE_IDLE))
        else $error("timeout reported outside idle phase");

    a_silent_no_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_NONE) |-> (len_reg == '0))
        else $error("nonzero length with nothing to send");

endmodule

/* design/uart_boot_image_sender.sv */
// ----------------------------------------------------------------------------
// uart_boot_image_sender
// Host side of a serial boot handshake: STX wait, SOH header, ACK wait,
// image send, checksum echo check, final ACK.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | payload
//  in_ch     | in  | valid/ready   | func, rx_count, rx_byte0..3
//  out_ch    | out | valid/ready   | tx_kind, tx_len, tx_byte0..2, phase,
//            |     |               | timed_out, finished
//  cfg       | in  | cfg_we        | cfg_index, cfg_data
//
//  One item per cycle while results are taken; each transfer in yields one registered result.
//  A poll is a single pass through the phase machine and the STX lanes.
//  A waiting result holds off the input; the next item enters in the same
//  cycle that result is taken, so a ready receiver sees no bubbles.
//  Reset (rst_n low, async) sets idle phase, clears the checksum and loads
//  the timeout counter and limit with their reset values.
// ----------------------------------------------------------------------------
module uart_boot_image_sender #(
    parameter int RX_LANES = ubs_pkg::RX_LANES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ubs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ubs_pkg::CFG_DATA_W-1:0]  cfg_data,
    ubs_in_if.sink                          in_ch,
    ubs_out_if.source                       out_ch
);
    import ubs_pkg::*;

    localparam int ACTIVE_LANES = (RX_LANES < RX_BYTES) ? RX_LANES : RX_BYTES;

    logic [LEN_W-1:0]   image_length_reg;
    logic [LIMIT_W-1:0] timeout_limit_reg;
    cfg_t               cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_length_reg  <= '0;
            timeout_limit_reg <= LIMIT_AT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_IMAGE_LENGTH:  image_length_reg  <= cfg_data[LEN_W-1:0];
                REG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.image_length  = image_length_reg;
    assign cfg.timeout_limit = timeout_limit_reg;

    ubs_core #(.NUM_LANES(ACTIVE_LANES)) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule
